// ----- sv/srpg_pkg.sv -----
`timescale 1ns / 1ps
// Package for the shape raster pixel generator: shape and action codes,
// the queued command record and the default display and arrow sizes.
// No dependencies; every other file of the block imports it.
package srpg_pkg;

	localparam int DEF_DISPLAY_WIDTH  = 320;
	localparam int DEF_DISPLAY_HEIGHT = 240;
	localparam int DEF_ARROW_WIDTH    = 35;
	localparam int DEF_ARROW_HEIGHT   = 18;

	// Area counters must hold the largest display side that is supported (4096).
	localparam int AREA_BITS = 13;

	// Entries in the queue between the classifier and the raster engine.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] BLACK_565 = 16'h0000;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_TICK  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		SHAPE_FILL       = 2'd0,
		SHAPE_OUTLINE    = 2'd1,
		SHAPE_ARROW_UP   = 2'd2,
		SHAPE_ARROW_DOWN = 2'd3
	} shape_t;

	// One classified transaction as it waits in the queue.
	typedef struct packed {
		logic                 is_tick;
		logic                 ok;
		shape_t               kind;
		logic [15:0]          x0;
		logic [15:0]          y0;
		logic [15:0]          x1;
		logic [15:0]          y1;
		logic [AREA_BITS-1:0] w;
		logic [AREA_BITS-1:0] h;
		logic [15:0]          border;
		logic [15:0]          colour;
	} cmd_t;

	// Queue status and pop handshake between the queue and the raster engine.
	typedef struct packed {
		logic valid;
		logic pop;
	} queue_ctl_t;

endpackage

// ----- sv/shape_raster_pixel_generator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the shape raster pixel generator: front end, queue and raster
// engine. Depends on srpg_pkg, srpg_front, srpg_queue and srpg_back.
//
//  Channel   Handshake               Payload
//  command   cmd_valid / cmd_ready   action, shape, pos_x, pos_y, size_w, size_h,
//                                    border, draw_colour
//  result    res_valid / res_ready   window_valid, rejected, win_x0..win_y1,
//                                    pixel_valid, pixel_colour, last_pixel
//
// One transaction in, one result out per clock, sustained with res_ready high.
// A command is classified on entry into a four-entry queue; the raster engine
// takes one entry per cycle into its result register while that register is
// empty or drains, so a command passes the queue and then the result register.
// Reset clears the queue pointers, the shape state and the result flag at once.
// A stalled result holds the engine while the queue keeps accepting until full.
module shape_raster_pixel_generator_unit import srpg_pkg::*; #(
	parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT,
	parameter int ARROW_WIDTH    = DEF_ARROW_WIDTH,
	parameter int ARROW_HEIGHT   = DEF_ARROW_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic        action,
	input  logic [1:0]  shape,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] size_w,
	input  logic [15:0] size_h,
	input  logic [15:0] border,
	input  logic [15:0] draw_colour,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        window_valid,
	output logic        rejected,
	output logic [15:0] win_x0,
	output logic [15:0] win_y0,
	output logic [15:0] win_x1,
	output logic [15:0] win_y1,
	output logic        pixel_valid,
	output logic [15:0] pixel_colour,
	output logic        last_pixel
);

	cmd_t       front_cmd;
	cmd_t       q_head;
	logic       q_full;
	logic       q_valid;
	logic       push;
	queue_ctl_t q_ctl;

	assign cmd_ready = !q_full;
	assign push      = cmd_valid && cmd_ready;

	srpg_front #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT),
		.ARROW_WIDTH   (ARROW_WIDTH),
		.ARROW_HEIGHT  (ARROW_HEIGHT)
	) u_front (
		.action     (action),
		.shape      (shape),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.size_w     (size_w),
		.size_h     (size_h),
		.border     (border),
		.draw_colour(draw_colour),
		.cmd        (front_cmd)
	);

	srpg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.ctl_in   (q_ctl),
		.not_empty(q_valid),
		.head     (q_head)
	);

	srpg_back #(
		.ARROW_WIDTH (ARROW_WIDTH),
		.ARROW_HEIGHT(ARROW_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_ctl       (q_ctl),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.window_valid(window_valid),
		.rejected    (rejected),
		.win_x0      (win_x0),
		.win_y0      (win_y0),
		.win_x1      (win_x1),
		.win_y1      (win_y1),
		.pixel_valid (pixel_valid),
		.pixel_colour(pixel_colour),
		.last_pixel  (last_pixel)
	);

	// An accepted transaction is always waiting in the queue in the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> q_valid)
		else $error("accepted transaction missing from queue");

	// A result answers either a start or a tick, never both.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !((window_valid || rejected) && pixel_valid))
		else $error("result mixes window and pixel fields");

	a_window_or_reject: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(window_valid && rejected))
		else $error("start both accepted and rejected");

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last_pixel) |-> pixel_valid)
		else $error("last pixel mark without pixel");

endmodule

// ----- sv/srpg_front.sv -----
`timescale 1ns / 1ps
// Front end of the shape raster pixel generator: checks each start command
// against the display and works out its window. Depends on srpg_pkg.
module srpg_front import srpg_pkg::*; #(
	parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT,
	parameter int ARROW_WIDTH    = DEF_ARROW_WIDTH,
	parameter int ARROW_HEIGHT   = DEF_ARROW_HEIGHT
) (
	input  logic        action,
	input  logic [1:0]  shape,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] size_w,
	input  logic [15:0] size_h,
	input  logic [15:0] border,
	input  logic [15:0] draw_colour,
	output cmd_t        cmd
);

	localparam int ARROW_HALF = ARROW_WIDTH / 2;

	logic [16:0] x_end;
	logic [16:0] y_end;
	logic [16:0] fill_w;
	logic [16:0] fill_h;
	logic [15:0] arrow_x0;
	logic [16:0] arrow_x_end;
	logic [16:0] arrow_y_end;

	assign x_end       = {1'b0, pos_x} + {1'b0, size_w};
	assign y_end       = {1'b0, pos_y} + {1'b0, size_h};
	assign fill_w      = (x_end > 17'(DISPLAY_WIDTH)) ? 17'(DISPLAY_WIDTH) - {1'b0, pos_x}
		: {1'b0, size_w};
	assign fill_h      = (y_end > 17'(DISPLAY_HEIGHT)) ? 17'(DISPLAY_HEIGHT) - {1'b0, pos_y}
		: {1'b0, size_h};
	assign arrow_x0    = pos_x - 16'(ARROW_HALF);
	assign arrow_x_end = {1'b0, arrow_x0} + 17'(ARROW_WIDTH);
	assign arrow_y_end = {1'b0, pos_y} + 17'(ARROW_HEIGHT);

	always_comb begin
		cmd         = '0;
		cmd.is_tick = (action == ACT_TICK);
		cmd.kind    = shape_t'(shape);
		cmd.y0      = pos_y;
		cmd.border  = border;
		cmd.colour  = draw_colour;
		unique case (shape_t'(shape))
			SHAPE_FILL: begin
				cmd.ok = (size_w != '0) && (size_h != '0) &&
					(pos_x < 16'(DISPLAY_WIDTH)) && (pos_y < 16'(DISPLAY_HEIGHT));
				cmd.x0 = pos_x;
				cmd.w  = AREA_BITS'(fill_w);
				cmd.h  = AREA_BITS'(fill_h);
				cmd.x1 = pos_x + 16'(fill_w) - 16'd1;
				cmd.y1 = pos_y + 16'(fill_h) - 16'd1;
			end
			SHAPE_OUTLINE: begin
				cmd.ok = (size_w != '0) && (size_h != '0) && (border != '0) &&
					(x_end <= 17'(DISPLAY_WIDTH)) && (y_end <= 17'(DISPLAY_HEIGHT));
				cmd.x0 = pos_x;
				cmd.w  = AREA_BITS'(size_w);
				cmd.h  = AREA_BITS'(size_h);
				cmd.x1 = pos_x + size_w - 16'd1;
				cmd.y1 = pos_y + size_h - 16'd1;
			end
			default: begin
				cmd.ok = (pos_x >= 16'(ARROW_HALF)) &&
					(arrow_x_end <= 17'(DISPLAY_WIDTH)) && (arrow_y_end <= 17'(DISPLAY_HEIGHT));
				cmd.x0 = arrow_x0;
				cmd.w  = AREA_BITS'(ARROW_WIDTH);
				cmd.h  = AREA_BITS'(ARROW_HEIGHT);
				cmd.x1 = arrow_x0 + 16'(ARROW_WIDTH - 1);
				cmd.y1 = pos_y + 16'(ARROW_HEIGHT - 1);
			end
		endcase
	end

endmodule

// ----- sv/srpg_queue.sv -----
`timescale 1ns / 1ps
// Short first-in first-out queue of classified transactions between the
// front end and the raster engine. Depends on srpg_pkg.
module srpg_queue import srpg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	output logic       full,
	input  queue_ctl_t ctl_in,
	output logic       not_empty,
	output cmd_t       head
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	cmd_t                entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign pop       = ctl_in.valid && ctl_in.pop && not_empty;
	assign full      = (count_q == CNT_BITS'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/srpg_back.sv -----
`timescale 1ns / 1ps
// Raster engine of the shape raster pixel generator: holds the shape in
// progress, walks it pixel by pixel and registers every result. Depends on srpg_pkg.
module srpg_back import srpg_pkg::*; #(
	parameter int ARROW_WIDTH  = DEF_ARROW_WIDTH,
	parameter int ARROW_HEIGHT = DEF_ARROW_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_head,
	output queue_ctl_t  q_ctl,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        window_valid,
	output logic        rejected,
	output logic [15:0] win_x0,
	output logic [15:0] win_y0,
	output logic [15:0] win_x1,
	output logic [15:0] win_y1,
	output logic        pixel_valid,
	output logic [15:0] pixel_colour,
	output logic        last_pixel
);

	localparam int ARROW_HALF = ARROW_WIDTH / 2;

	logic                 busy_q;
	shape_t               kind_q;
	logic [AREA_BITS-1:0] col_q;
	logic [AREA_BITS-1:0] row_q;
	logic [AREA_BITS-1:0] w_q;
	logic [AREA_BITS-1:0] h_q;
	logic [15:0]          border_q;
	logic [15:0]          colour_q;

	logic                 res_valid_q;
	logic                 window_valid_q;
	logic                 rejected_q;
	logic [15:0]          win_x0_q;
	logic [15:0]          win_y0_q;
	logic [15:0]          win_x1_q;
	logic [15:0]          win_y1_q;
	logic                 pixel_valid_q;
	logic [15:0]          pixel_colour_q;
	logic                 last_pixel_q;

	logic                 pop;
	logic                 last_col;
	logic                 last_row;
	logic                 on_border;
	logic [AREA_BITS-1:0] col_off;
	logic [AREA_BITS-1:0] half;
	logic [15:0]          colour_now;

	// A new transaction moves in whenever the result register is empty or drains.
	assign pop         = q_valid && (!res_valid_q || res_ready);
	assign q_ctl.valid = q_valid;
	assign q_ctl.pop   = pop;

	assign last_col = ({1'b0, col_q} + 1'b1) >= {1'b0, w_q};
	assign last_row = ({1'b0, row_q} + 1'b1) >= {1'b0, h_q};

	assign on_border = ({3'b0, row_q} < border_q) ||
		(({4'b0, row_q} + {1'b0, border_q}) >= {4'b0, h_q}) ||
		({3'b0, col_q} < border_q) ||
		(({4'b0, col_q} + {1'b0, border_q}) >= {4'b0, w_q});

	assign col_off = (col_q >= AREA_BITS'(ARROW_HALF)) ? col_q - AREA_BITS'(ARROW_HALF)
		: AREA_BITS'(ARROW_HALF) - col_q;
	assign half = (kind_q == SHAPE_ARROW_UP) ? row_q : AREA_BITS'(ARROW_HEIGHT - 1) - row_q;

	always_comb begin
		unique case (kind_q) inside
			SHAPE_FILL:                       colour_now = colour_q;
			SHAPE_OUTLINE:                    colour_now = on_border ? colour_q : BLACK_565;
			SHAPE_ARROW_UP, SHAPE_ARROW_DOWN: colour_now = (col_off <= half) ? colour_q
				: BLACK_565;
			default:                          colour_now = BLACK_565;
		endcase
	end

	// Shape state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			kind_q      <= SHAPE_FILL;
			col_q       <= '0;
			row_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				if (!q_head.is_tick) begin
					// A start abandons any shape in progress.
					busy_q <= q_head.ok;
					col_q  <= '0;
					row_q  <= '0;
					if (q_head.ok) begin
						kind_q <= q_head.kind;
					end
				end else if (busy_q) begin
					if (last_col) begin
						col_q <= '0;
						if (last_row) begin
							busy_q <= 1'b0;
							row_q  <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	// Shape geometry and the result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (!q_head.is_tick && q_head.ok) begin
				w_q      <= q_head.w;
				h_q      <= q_head.h;
				border_q <= q_head.border;
				colour_q <= q_head.colour;
			end
			window_valid_q <= !q_head.is_tick && q_head.ok;
			rejected_q     <= !q_head.is_tick && !q_head.ok;
			win_x0_q       <= (!q_head.is_tick && q_head.ok) ? q_head.x0 : '0;
			win_y0_q       <= (!q_head.is_tick && q_head.ok) ? q_head.y0 : '0;
			win_x1_q       <= (!q_head.is_tick && q_head.ok) ? q_head.x1 : '0;
			win_y1_q       <= (!q_head.is_tick && q_head.ok) ? q_head.y1 : '0;
			pixel_valid_q  <= q_head.is_tick && busy_q;
			pixel_colour_q <= (q_head.is_tick && busy_q) ? colour_now : '0;
			last_pixel_q   <= q_head.is_tick && busy_q && last_col && last_row;
		end
	end

	assign res_valid    = res_valid_q;
	assign window_valid = window_valid_q;
	assign rejected     = rejected_q;
	assign win_x0       = win_x0_q;
	assign win_y0       = win_y0_q;
	assign win_x1       = win_x1_q;
	assign win_y1       = win_y1_q;
	assign pixel_valid  = pixel_valid_q;
	assign pixel_colour = pixel_colour_q;
	assign last_pixel   = last_pixel_q;

endmodule

// ----- dv/shape_raster_pixel_generator_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for shape_raster_pixel_generator_unit: a stimulus table, then
// random draw sequences. Typed table rows are scored against their expected results,
// others against a behavioral raster predictor. Depends on srpg_pkg and block RTL.
module shape_raster_pixel_generator_unit_test;
	import srpg_pkg::*;

	localparam int DISP_W = DEF_DISPLAY_WIDTH;
	localparam int DISP_H = DEF_DISPLAY_HEIGHT;
	localparam int ARROW_W = DEF_ARROW_WIDTH;
	localparam int ARROW_H = DEF_ARROW_HEIGHT;
	localparam int RANDOM_ITEMS = 1250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		action_t     act;
		shape_t      shp;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] thick;
		logic [15:0] colour;
	} cmd_item_t;

	typedef struct packed {
		logic        window_valid;
		logic        rejected;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic        pixel_valid;
		logic [15:0] pixel_colour;
		logic        last_pixel;
	} pixel_result_t;

	typedef struct {
		cmd_item_t     item;
		bit            typed;
		pixel_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	logic        action = 1'b0;
	logic [1:0]  shape = 2'd0;
	logic [15:0] pos_x = 16'd0;
	logic [15:0] pos_y = 16'd0;
	logic [15:0] size_w = 16'd0;
	logic [15:0] size_h = 16'd0;
	logic [15:0] border = 16'd0;
	logic [15:0] draw_colour = 16'd0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        window_valid;
	logic        rejected;
	logic [15:0] win_x0;
	logic [15:0] win_y0;
	logic [15:0] win_x1;
	logic [15:0] win_y1;
	logic        pixel_valid;
	logic [15:0] pixel_colour;
	logic        last_pixel;

	shape_raster_pixel_generator_unit dut (.*);

	always #4 clk = ~clk;

	// Predicted generator state.
	bit          gen_busy = 1'b0;
	shape_t      gen_shape = SHAPE_FILL;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned span_w = 0;
	int unsigned span_h = 0;
	int unsigned ring_thick = 0;
	logic [15:0] ink_colour = 16'h0000;

	pixel_result_t pending_results[$];
	dir_row_t      directed_rows[$];
	int            items_sent = 0;
	int            rand_base = 0;
	int            results_seen = 0;
	int            miss_count = 0;
	int            idle_cycles = 0;
	int            gap_pct = 0;
	int            stall_pct = 0;
	int            hold_left = 0;
	bit            hold_done = 1'b0;

	function automatic logic [15:0] shade_at(int unsigned col, int unsigned row);
		int unsigned centre;
		int unsigned col_off;
		int unsigned half;
		centre = ARROW_W / 2;
		case (gen_shape)
			SHAPE_FILL: return ink_colour;
			SHAPE_OUTLINE: begin
				if (row < ring_thick || row + ring_thick >= span_h ||
				    col < ring_thick || col + ring_thick >= span_w)
					return ink_colour;
				return BLACK_565;
			end
			default: begin
				col_off = (col >= centre) ? col - centre : centre - col;
				half = (gen_shape == SHAPE_ARROW_UP) ? row : ARROW_H - 1 - row;
				return (col_off <= half) ? ink_colour : BLACK_565;
			end
		endcase
	endfunction

	function automatic pixel_result_t raster_step(cmd_item_t it);
		pixel_result_t r;
		int unsigned w;
		int unsigned h;
		int unsigned x0;
		bit ok;
		r = '0;
		x0 = 0;
		ok = 1'b0;
		if (it.act == ACT_TICK) begin
			if (gen_busy) begin
				r.pixel_valid = 1'b1;
				r.pixel_colour = shade_at(col_pos, row_pos);
				if (col_pos + 1 >= span_w) begin
					col_pos = 0;
					if (row_pos + 1 >= span_h) begin
						r.last_pixel = 1'b1;
						gen_busy = 1'b0;
						row_pos = 0;
					end else begin
						row_pos++;
					end
				end else begin
					col_pos++;
				end
			end
			return r;
		end
		// Any start abandons the shape in progress.
		gen_busy = 1'b0;
		col_pos = 0;
		row_pos = 0;
		w = it.w;
		h = it.h;
		case (it.shp)
			SHAPE_FILL: begin
				if (w != 0 && h != 0 && it.x < DISP_W && it.y < DISP_H) begin
					if (it.x + w > DISP_W)
						w = DISP_W - it.x;
					if (it.y + h > DISP_H)
						h = DISP_H - it.y;
					x0 = it.x;
					ok = 1'b1;
				end
			end
			SHAPE_OUTLINE: begin
				if (w != 0 && h != 0 && it.thick != 0 &&
				    it.x + w <= DISP_W && it.y + h <= DISP_H) begin
					x0 = it.x;
					ok = 1'b1;
				end
			end
			default: begin
				w = ARROW_W;
				h = ARROW_H;
				if (it.x >= ARROW_W / 2) begin
					x0 = it.x - ARROW_W / 2;
					if (x0 + w <= DISP_W && it.y + h <= DISP_H)
						ok = 1'b1;
				end
			end
		endcase
		if (!ok) begin
			r.rejected = 1'b1;
			return r;
		end
		gen_busy = 1'b1;
		gen_shape = it.shp;
		span_w = w;
		span_h = h;
		ring_thick = it.thick;
		ink_colour = it.colour;
		r.window_valid = 1'b1;
		r.x0 = 16'(x0);
		r.y0 = it.y;
		r.x1 = 16'(x0 + w - 1);
		r.y1 = 16'(it.y + h - 1);
		return r;
	endfunction

	function automatic cmd_item_t mk_cmd(action_t a, shape_t s, logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] h, logic [15:0] b, logic [15:0] c);
		cmd_item_t it;
		it.act = a;
		it.shp = s;
		it.x = x;
		it.y = y;
		it.w = w;
		it.h = h;
		it.thick = b;
		it.colour = c;
		return it;
	endfunction

	function automatic cmd_item_t random_item(action_t a);
		return mk_cmd(a, shape_t'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
	endfunction

	function automatic pixel_result_t res_window(logic [15:0] x0, logic [15:0] y0,
			logic [15:0] x1, logic [15:0] y1);
		pixel_result_t r;
		r = '0;
		r.window_valid = 1'b1;
		r.x0 = x0;
		r.y0 = y0;
		r.x1 = x1;
		r.y1 = y1;
		return r;
	endfunction

	function automatic pixel_result_t res_pixel(logic [15:0] c, logic last);
		pixel_result_t r;
		r = '0;
		r.pixel_valid = 1'b1;
		r.pixel_colour = c;
		r.last_pixel = last;
		return r;
	endfunction

	function automatic dir_row_t row_typed(cmd_item_t it, pixel_result_t want);
		dir_row_t row;
		row.item = it;
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic dir_row_t row_open(cmd_item_t it);
		dir_row_t row;
		row.item = it;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic string show(pixel_result_t r);
		return $sformatf("win=%0b rej=%0b (%0d,%0d)-(%0d,%0d) pix=%0b colour=%h last=%0b",
			r.window_valid, r.rejected, r.x0, r.y0, r.x1, r.y1,
			r.pixel_valid, r.pixel_colour, r.last_pixel);
	endfunction

	// Drives one transaction from a falling edge and returns at the falling edge after
	// it was taken.
	task automatic send_item(cmd_item_t it, bit typed, pixel_result_t want);
		pixel_result_t predicted;
		while ($urandom_range(0, 99) < gap_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		action = it.act;
		shape = it.shp;
		pos_x = it.x;
		pos_y = it.y;
		size_w = it.w;
		size_h = it.h;
		border = it.thick;
		draw_colour = it.colour;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		predicted = raster_step(it);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic run_random();
		int unsigned pick;
		int unsigned pixels;
		int unsigned ticks;
		int phase;
		cmd_item_t it;
		while (items_sent < rand_base + RANDOM_ITEMS) begin
			phase = (items_sent - rand_base) * 4 / RANDOM_ITEMS;
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 64; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 64; end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick >= 88) begin
				// A few stray ticks, mostly landing on an idle generator.
				repeat ($urandom_range(1, 3))
					send_item(random_item(ACT_TICK), 1'b0, '0);
				continue;
			end
			it = random_item(ACT_START);
			if (pick < 30) begin
				it.shp = SHAPE_FILL;
				it.w = 16'($urandom_range(1, 6));
				it.h = 16'($urandom_range(1, 5));
				it.x = 16'($urandom_range(0, DISP_W - 1));
				it.y = 16'($urandom_range(0, DISP_H - 1));
				if ($urandom_range(0, 3) == 0) begin
					it.x = 16'(DISP_W - $urandom_range(1, 6));
					it.w = 16'($urandom_range(1, 65535));
				end
				if ($urandom_range(0, 3) == 0) begin
					it.y = 16'(DISP_H - $urandom_range(1, 4));
					it.h = 16'($urandom_range(1, 65535));
				end
			end else if (pick < 55) begin
				it.shp = SHAPE_OUTLINE;
				it.w = 16'($urandom_range(1, 7));
				it.h = 16'($urandom_range(1, 7));
				it.thick = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(4, 65535))
					: 16'($urandom_range(1, 3));
				it.x = 16'($urandom_range(0, DISP_W - it.w));
				it.y = 16'($urandom_range(0, DISP_H - it.h));
				if ($urandom_range(0, 9) == 0)
					it.thick = 16'd0;
				else if ($urandom_range(0, 9) == 0)
					it.x = 16'(DISP_W - it.w + $urandom_range(1, 3));
			end else if (pick < 70) begin
				it.shp = $urandom_range(0, 1) ? SHAPE_ARROW_UP : SHAPE_ARROW_DOWN;
				it.x = 16'($urandom_range(ARROW_W / 2, DISP_W - ARROW_W + ARROW_W / 2));
				it.y = 16'($urandom_range(0, DISP_H - ARROW_H));
				if ($urandom_range(0, 9) == 0)
					it.x = 16'($urandom_range(0, ARROW_W / 2 - 1));
				else if ($urandom_range(0, 9) == 0)
					it.y = 16'(DISP_H - ARROW_H + $urandom_range(1, 5));
			end
			send_item(it, 1'b0, '0);
			pixels = gen_busy ? span_w * span_h : 0;
			if (pixels == 0)
				ticks = $urandom_range(0, 1);
			else if ((pixels <= 64 && $urandom_range(0, 4) != 0) ||
			         (pixels > 64 && pixels <= ARROW_W * ARROW_H && $urandom_range(0, 5) == 0))
				ticks = pixels + (($urandom_range(0, 4) == 0) ? 1 : 0);
			else
				ticks = $urandom_range(0, (pixels < 40) ? pixels - 1 : 40);
			repeat (ticks)
				send_item(random_item(ACT_TICK), 1'b0, '0);
		end
	endtask

	// Result side: random stalls, plus one long hold-off early on so that the block
	// backs up into its input.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			res_ready = 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen >= 120) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_ready = 1'b0;
		end else begin
			res_ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		pixel_result_t seen;
		pixel_result_t want;
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && res_valid && res_ready) begin
			seen.window_valid = window_valid;
			seen.rejected = rejected;
			seen.x0 = win_x0;
			seen.y0 = win_y0;
			seen.x1 = win_x1;
			seen.y1 = win_y1;
			seen.pixel_valid = pixel_valid;
			seen.pixel_colour = pixel_colour;
			seen.last_pixel = last_pixel;
			results_seen++;
			if (pending_results.size() == 0) begin
				miss_count++;
				if (miss_count <= 10)
					$display("%0t: result with nothing expected: %s", $realtime, show(seen));
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					miss_count++;
					if (miss_count <= 10) begin
						$display("%0t: result %0d mismatch", $realtime, results_seen);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(seen));
					end
				end
			end
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		cmd_item_t tick_ones;
		tick_ones = mk_cmd(ACT_TICK, SHAPE_ARROW_DOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF);

		// Tick on an idle generator right after reset.
		directed_rows.push_back(row_typed(tick_ones, '0));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_FILL, 0, 0, 0, 5, 0, 16'h1111),
			'{rejected: 1'b1, default: '0}));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_FILL, 16'hFFFF, 0, 16'hFFFF,
			16'hFFFF, 0, 16'hFFFF), '{rejected: 1'b1, default: '0}));
		// Fill hanging off the bottom right corner is clipped.
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_FILL, 310, 230, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF), res_window(310, 230, 319, 239)));
		// A new start abandons the clipped fill.
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_FILL, 0, 0, 2, 1, 0, 16'hA5A5),
			res_window(0, 0, 1, 0)));
		directed_rows.push_back(row_typed(tick_ones, res_pixel(16'hA5A5, 1'b0)));
		directed_rows.push_back(row_typed(tick_ones, res_pixel(16'hA5A5, 1'b1)));
		directed_rows.push_back(row_typed(tick_ones, '0));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_OUTLINE, 0, 0, 3, 3, 0, 16'h1234),
			'{rejected: 1'b1, default: '0}));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_OUTLINE, 1, 0, 320, 1, 1,
			16'h1234), '{rejected: 1'b1, default: '0}));
		// Three by three ring: only the middle pixel is black.
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_OUTLINE, 0, 0, 3, 3, 1, 16'h5A5A),
			res_window(0, 0, 2, 2)));
		repeat (9)
			directed_rows.push_back(row_open(tick_ones));
		// Border thicker than half the rectangle paints everything.
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_OUTLINE, 100, 100, 4, 1,
			16'hFFFF, 16'h0F0F), res_window(100, 100, 103, 100)));
		directed_rows.push_back(row_open(tick_ones));
		directed_rows.push_back(row_open(tick_ones));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_ARROW_UP, 16, 0, 0, 0, 0,
			16'hF800), '{rejected: 1'b1, default: '0}));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_ARROW_UP, 17, 0, 0, 0, 0,
			16'hF800), res_window(0, 0, 34, 17)));
		directed_rows.push_back(row_open(tick_ones));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_ARROW_DOWN, 302, 222, 0, 0, 0,
			16'h07E0), res_window(285, 222, 319, 239)));
		directed_rows.push_back(row_typed(mk_cmd(ACT_START, SHAPE_ARROW_DOWN, 303, 222, 0, 0, 0,
			16'h07E0), '{rejected: 1'b1, default: '0}));
		// A rejected start leaves the generator idle.
		directed_rows.push_back(row_typed(tick_ones, '0));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		rand_base = items_sent;
		run_random();
		cmd_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (miss_count == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
sv/srpg_pkg.sv
sv/srpg_front.sv
sv/srpg_queue.sv
sv/srpg_back.sv
sv/shape_raster_pixel_generator_unit.sv
dv/shape_raster_pixel_generator_unit_test.sv
